// ===== sv/pcc_pkg.sv =====
// Shared types, constants and elaboration-time functions for the polar/cartesian converter.
// No dependencies; used by pcc_cell, pcc_scale and polar_cartesian_convert.
package pcc_pkg;

  localparam int FRAC_G  = 8;   // fraction bits of coordinates inside the CORDIC
  localparam int ANGLE_W = 16;  // binary angle width, 2^15 counts per pi
  localparam int ZW      = 33;  // angle accumulator, 2^16 units per count
  localparam int KW      = 21;  // gain constant width

  typedef struct packed {
    logic valid;
    logic kind;   // 0: cartesian to polar, 1: polar to cartesian
    logic zero;   // zero vector, kind 0 only
  } ctl_t;

  typedef enum logic {
    KIND_TO_POLAR = 1'b0,
    KIND_TO_CART  = 1'b1
  } kind_t;

  function automatic logic [31:0] atan_val(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41721;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // K = round(2^50 / isqrt(2^60 * prod(1 + 4^-i))), evaluated at elaboration
  function automatic logic [KW-1:0] gain_q20(input int n);
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] t;
    p = 64'd1 << 60;
    for (int i = 0; i < 24; i++) begin
      if (i < n) begin
        p = p + (p >> (2 * i));
      end
    end
    v = p;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) begin
        b = b >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    num = (64'd1 << 50) + (r >> 1);
    q   = 64'd0;
    for (int i = 22; i >= 0; i--) begin
      t = q | (64'd1 << i);
      if (t * r <= num) begin
        q = t;
      end
    end
    return q[KW-1:0];
  endfunction

endpackage

// ===== sv/pcc_cell.sv =====
// One CORDIC micro-rotation stage with its pipeline register.
// Depends on pcc_pkg.
module pcc_cell
  import pcc_pkg::*;
#(
  parameter int IDX = 0,
  parameter int DW  = 27
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ctl_t                 ctl_i,
  input  logic signed [DW-1:0] x_i,
  input  logic signed [DW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output ctl_t                 ctl_o,
  output logic signed [DW-1:0] x_o,
  output logic signed [DW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic [31:0] ATAN = atan_val(5'(IDX));

  ctl_t                 ctl_r;
  logic signed [DW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt, za;
  logic                 sub;

  // vectoring steers on the sign of y, rotation on the sign of z
  assign sub = (ctl_i.kind == KIND_TO_CART) ? ~z_i[ZW-1] : y_i[DW-1];
  assign xs  = x_i >>> IDX;
  assign ys  = y_i >>> IDX;
  assign za  = ZW'(signed'({1'b0, ATAN}));

  always_comb begin
    if (sub) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - za;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + za;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

// ===== sv/pcc_scale.sv =====
// Gain compensation, rounding, saturation and the output register.
// Depends on pcc_pkg.
module pcc_scale
  import pcc_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int STEPS       = 16,
  parameter int DW          = 27
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  ctl_t                          ctl_i,
  input  logic signed [DW-1:0]          x_i,
  input  logic signed [DW-1:0]          y_i,
  input  logic signed [ZW-1:0]          z_i,
  output logic                          valid_o,
  output logic        [COORD_WIDTH-1:0] x_o,
  output logic        [COORD_WIDTH-1:0] y_o,
  output logic        [COORD_WIDTH-1:0] radius_o,
  output logic        [ANGLE_W-1:0]     angle_o
);

  localparam int               MW   = DW + KW;
  localparam int               PW   = MW - 28;
  localparam logic [KW-1:0]    K    = gain_q20(STEPS);
  localparam logic [PW-1:0]    LIM  = PW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic [PW-1:0]    RMAX = PW'((64'd1 << COORD_WIDTH) - 64'd1);
  localparam logic [MW-1:0]    HALF = MW'(64'd1 << 27);

  ctl_t                   ctl_r;
  logic [MW-1:0]          px_r, py_r;
  logic                   sx_r, sy_r;
  logic [31:0]            z_r;
  logic [DW-1:0]          mx, my;
  logic [MW-1:0]          rx_sum, ry_sum;
  logic [PW-1:0]          rx, ry, cx, cy;
  logic [31:0]            a_sum;

  logic                   valid_r;
  logic [COORD_WIDTH-1:0] x_r, y_r, radius_r, x_nxt, y_nxt, radius_nxt;
  logic [ANGLE_W-1:0]     angle_r, angle_nxt;

  assign mx = x_i[DW-1] ? DW'(-x_i) : DW'(x_i);
  assign my = y_i[DW-1] ? DW'(-y_i) : DW'(y_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= MW'(mx) * MW'(K);
      py_r <= MW'(my) * MW'(K);
      sx_r <= x_i[DW-1];
      sy_r <= y_i[DW-1];
      z_r  <= z_i[31:0];
    end
  end

  // round half away from zero on the magnitude, then restore the sign
  assign rx_sum = px_r + HALF;
  assign ry_sum = py_r + HALF;
  assign rx     = rx_sum[MW-1:28];
  assign ry     = ry_sum[MW-1:28];
  assign cx     = (rx > LIM) ? LIM : rx;
  assign cy     = (ry > LIM) ? LIM : ry;
  assign a_sum  = z_r + 32'h0000_8000;

  always_comb begin
    x_nxt      = '0;
    y_nxt      = '0;
    radius_nxt = '0;
    angle_nxt  = '0;
    if (ctl_r.kind == KIND_TO_CART) begin
      x_nxt = sx_r ? COORD_WIDTH'(-cx) : cx[COORD_WIDTH-1:0];
      y_nxt = sy_r ? COORD_WIDTH'(-cy) : cy[COORD_WIDTH-1:0];
    end else if (!ctl_r.zero) begin
      radius_nxt = sx_r ? '0 : ((rx > RMAX) ? RMAX[COORD_WIDTH-1:0] : rx[COORD_WIDTH-1:0]);
      angle_nxt  = a_sum[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      radius_r <= radius_nxt;
      angle_r  <= angle_nxt;
    end
  end

  assign valid_o  = valid_r;
  assign x_o      = x_r;
  assign y_o      = y_r;
  assign radius_o = radius_r;
  assign angle_o  = angle_r;

endmodule

// ===== sv/polar_cartesian_convert.sv =====
// Polar/cartesian vector converter: pre-rotation stage, CORDIC_STEPS cells, gain stage.
// One transaction per cycle sustained while results are accepted, set by one cell per
// micro-rotation in a fully pipelined row.
// A stalled result holds the whole pipeline in place.
// Synchronous active-low reset clears all valid flags; data registers are not reset.
// Depends on pcc_pkg, pcc_cell and pcc_scale.
module polar_cartesian_convert
  import pcc_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // x_in, y_in, radius_in, angle_in, zero pad
  input  logic [((3*COORD_WIDTH+15+7)/8)*8-1:0] in_tdata,
  // kind
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // x_out, y_out, radius_out, angle_out, zero pad
  output logic [((3*COORD_WIDTH+16+7)/8)*8-1:0] out_tdata
);

  localparam int W      = COORD_WIDTH;
  localparam int DW     = COORD_WIDTH + FRAC_G + 3;
  localparam int OUT_DW = ((3*COORD_WIDTH+16+7)/8)*8;

  logic                  en;
  logic signed [W-1:0]   x_in, y_in;
  logic        [W-2:0]   radius_in;
  logic signed [15:0]    angle_in;
  logic signed [16:0]    a_ext, a_adj;
  logic signed [DW-1:0]  xe, ye, re;

  ctl_t                  pre_ctl_nxt;
  logic signed [DW-1:0]  pre_x_nxt, pre_y_nxt;
  logic signed [ZW-1:0]  pre_z_nxt;

  ctl_t                  c_ctl [0:CORDIC_STEPS];
  logic signed [DW-1:0]  c_x   [0:CORDIC_STEPS];
  logic signed [DW-1:0]  c_y   [0:CORDIC_STEPS];
  logic signed [ZW-1:0]  c_z   [0:CORDIC_STEPS];

  ctl_t                  pre_ctl_r;
  logic signed [DW-1:0]  pre_x_r, pre_y_r;
  logic signed [ZW-1:0]  pre_z_r;

  logic [W-1:0]          x_out, y_out, radius_out;
  logic [ANGLE_W-1:0]    angle_out;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign x_in      = in_tdata[W-1:0];
  assign y_in      = in_tdata[2*W-1:W];
  assign radius_in = in_tdata[3*W-2:2*W];
  assign angle_in  = in_tdata[3*W+14:3*W-1];

  assign xe    = DW'(x_in);
  assign ye    = DW'(y_in);
  assign re    = DW'(signed'({1'b0, radius_in}));
  assign a_ext = 17'(angle_in);
  assign a_adj = (a_ext > 17'sd0) ? a_ext - 17'sd32768 : a_ext + 17'sd32768;

  always_comb begin
    pre_ctl_nxt.valid = in_tvalid;
    pre_ctl_nxt.kind  = in_tuser;
    pre_ctl_nxt.zero  = (x_in == '0) && (y_in == '0);
    if (in_tuser == KIND_TO_CART) begin
      pre_y_nxt = '0;
      if (a_ext > 17'sd16384 || a_ext < -17'sd16384) begin
        pre_x_nxt = (-re) <<< FRAC_G;
        pre_z_nxt = ZW'({a_adj, 16'h0000});
      end else begin
        pre_x_nxt = re <<< FRAC_G;
        pre_z_nxt = ZW'({a_ext, 16'h0000});
      end
    end else begin
      // left half plane: turn by pi first
      if (x_in[W-1]) begin
        pre_x_nxt = (-xe) <<< FRAC_G;
        pre_y_nxt = (-ye) <<< FRAC_G;
        pre_z_nxt = ZW'(64'd1 << 31);
      end else begin
        pre_x_nxt = xe <<< FRAC_G;
        pre_y_nxt = ye <<< FRAC_G;
        pre_z_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_ctl_r <= '0;
    end else if (en) begin
      pre_ctl_r <= pre_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_x_r <= pre_x_nxt;
      pre_y_r <= pre_y_nxt;
      pre_z_r <= pre_z_nxt;
    end
  end

  assign c_ctl[0] = pre_ctl_r;
  assign c_x[0]   = pre_x_r;
  assign c_y[0]   = pre_y_r;
  assign c_z[0]   = pre_z_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    pcc_cell #(
      .IDX (g),
      .DW  (DW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (c_ctl[g]),
      .x_i   (c_x[g]),
      .y_i   (c_y[g]),
      .z_i   (c_z[g]),
      .ctl_o (c_ctl[g+1]),
      .x_o   (c_x[g+1]),
      .y_o   (c_y[g+1]),
      .z_o   (c_z[g+1])
    );
  end

  pcc_scale #(
    .COORD_WIDTH (COORD_WIDTH),
    .STEPS       (CORDIC_STEPS),
    .DW          (DW)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctl_i    (c_ctl[CORDIC_STEPS]),
    .x_i      (c_x[CORDIC_STEPS]),
    .y_i      (c_y[CORDIC_STEPS]),
    .z_i      (c_z[CORDIC_STEPS]),
    .valid_o  (out_tvalid),
    .x_o      (x_out),
    .y_o      (y_out),
    .radius_o (radius_out),
    .angle_o  (angle_out)
  );

  assign out_tdata = OUT_DW'({angle_out, radius_out, y_out, x_out});

endmodule

// ===== sim/polar_cartesian_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for polar_cartesian_convert: watches both stream channels, computes the
// fixed-point CORDIC result of every accepted vector and compares it field by field.
// Depends on pcc_pkg for the kind encoding.
module polar_cartesian_checker
  import pcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  output int          mismatch_count,
  output int          results_pending
);

  localparam int STEPS = 16;
  localparam int CW    = 16;

  typedef struct packed {
    logic signed [15:0] ang;
    logic        [15:0] rad;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vec_result_t;

  localparam logic [31:0] ATAN_STEP [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  vec_result_t pending_vectors[$];
  int          fail_cnt    = 0;
  int          pending_cnt = 0;

  assign mismatch_count  = fail_cnt;
  assign results_pending = pending_cnt;

  // 1 / prod(sqrt(1 + 4^-i)) in Q20, from an integer square root of the truncated product
  function automatic longint unsigned cordic_gain();
    longint unsigned p;
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    p = 64'd1 << 60;
    for (int i = 0; i < STEPS; i++) begin
      p = p + (p >> (2 * i));
    end
    rem   = p;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rem) begin
      probe = probe >> 2;
    end
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return ((64'd1 << 50) + root / 2) / root;
  endfunction

  longint unsigned gain_k = cordic_gain();

  // round half away from zero of v * K / 2^28
  function automatic longint gain_scale(input longint v);
    longint unsigned m;
    longint unsigned p;
    m = (v < 0) ? longint'(-v) : longint'(v);
    p = (m * gain_k + (64'd1 << 27)) >> 28;
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [15:0] clamp_coord(input longint v);
    longint lim;
    lim = (64'sd1 <<< (CW - 1)) - 1;
    if (v > lim) return lim[15:0];
    if (v < -lim) return 16'(-lim);
    return v[15:0];
  endfunction

  function automatic vec_result_t convert_vector(input kind_t kind, input logic [63:0] word);
    logic signed [15:0] xs;
    logic signed [15:0] ys;
    logic signed [15:0] as;
    logic        [14:0] rs;
    longint             cx;
    longint             cy;
    longint             nx;
    longint             ny;
    longint             za;
    longint             mag;
    logic        [31:0] zc;
    logic        [32:0] zr;
    vec_result_t        res;
    res = '0;
    xs  = word[15:0];
    ys  = word[31:16];
    rs  = word[46:32];
    as  = word[62:47];
    if (kind == KIND_TO_POLAR) begin
      if (xs != 0 || ys != 0) begin
        cx = xs;
        cy = ys;
        zc = '0;
        if (cx < 0) begin
          cx = -cx;
          cy = -cy;
          zc = 32'h8000_0000;
        end
        cx = cx * 256;
        cy = cy * 256;
        for (int i = 0; i < STEPS; i++) begin
          if (cy >= 0) begin
            nx = cx + (cy >>> i);
            ny = cy - (cx >>> i);
            zc = zc + ATAN_STEP[i];
          end else begin
            nx = cx - (cy >>> i);
            ny = cy + (cx >>> i);
            zc = zc - ATAN_STEP[i];
          end
          cx = nx;
          cy = ny;
        end
        mag = gain_scale(cx);
        if (mag < 0) mag = 0;
        if (mag > 65535) mag = 65535;
        res.rad = mag[15:0];
        zr      = {1'b0, zc} + 33'h8000;
        res.ang = zr[31:16];
      end
    end else begin
      cx = longint'(rs);
      za = as;
      // fold the back half-plane onto the front one by negating the radius
      if (za > 16384 || za < -16384) begin
        cx = -cx;
        za = (za > 0) ? za - 32768 : za + 32768;
      end
      za = za * 65536;
      cx = cx * 256;
      cy = 0;
      for (int i = 0; i < STEPS; i++) begin
        if (za >= 0) begin
          nx = cx - (cy >>> i);
          ny = cy + (cx >>> i);
          za = za - longint'(ATAN_STEP[i]);
        end else begin
          nx = cx + (cy >>> i);
          ny = cy - (cx >>> i);
          za = za + longint'(ATAN_STEP[i]);
        end
        cx = nx;
        cy = ny;
      end
      res.x = clamp_coord(gain_scale(cx));
      res.y = clamp_coord(gain_scale(cy));
    end
    return res;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    vec_result_t got;
    vec_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_vectors.push_back(convert_vector(kind_t'(in_tuser), in_tdata));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_vectors.size() == 0) begin
          $error("unexpected result transaction: %h", out_tdata);
          fail_cnt++;
        end else begin
          want = pending_vectors.pop_front();
          check_field("x_out", want.x, got.x);
          check_field("y_out", want.y, got.y);
          check_field("radius_out", want.rad, got.rad);
          check_field("angle_out", want.ang, got.ang);
        end
      end
      pending_cnt = pending_vectors.size();
    end
  end

endmodule

// ===== sim/polar_cartesian_convert_tb.sv =====
`timescale 1ns / 1ps
// Top of the polar_cartesian_convert testbench: clock, reset, vector stimulus with bursty
// input and stalling output, timeout and verdict. Depends on pcc_pkg, the DUT and
// polar_cartesian_checker.
module polar_cartesian_convert_tb;
  import pcc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 450;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // x_in, y_in, radius_in, angle_in, zero pad
  logic        in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // x_out, y_out, radius_out, angle_out

  int mismatch_count;
  int results_pending;
  int cycle_count  = 0;
  int sent_count   = 0;
  int burst_left   = 0;
  bit backlog_done = 1'b0;

  always #1 clk = ~clk;

  polar_cartesian_convert u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  polar_cartesian_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic offer_vector(input kind_t kind, input logic [15:0] x, input logic [15:0] y,
                              input logic [14:0] radius, input logic [15:0] angle);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, angle, radius, y, x};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sent_count++;
  endtask

  // biased toward the extremes and the neighborhood of zero
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(0, 31)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  // output side: randomly changing stall patterns, one long hold-off early on
  initial begin
    int mode;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      for (int c = 0; c < 48; c++) begin
        if (!backlog_done && sent_count >= 60) begin
          backlog_done = 1'b1;
          out_tready <= 1'b0;
          repeat (300) @(posedge clk);
        end
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 7) != 0);
          default: out_tready <= ($urandom_range(0, 5) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [14:0] radius;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // cartesian to polar: zero vector, corners, axes, angle of pi
    offer_vector(KIND_TO_POLAR, 16'h0000, 16'h0000, 15'h7FFF, 16'h1234);
    offer_vector(KIND_TO_POLAR, 16'h8000, 16'h8000, 15'h0000, 16'h0000);
    offer_vector(KIND_TO_POLAR, 16'h7FFF, 16'h7FFF, 15'h1555, 16'hFFFF);
    offer_vector(KIND_TO_POLAR, 16'h8000, 16'h0000, 15'h0000, 16'h0000);
    offer_vector(KIND_TO_POLAR, 16'hFFFF, 16'h0000, 15'h7FFF, 16'h8000);
    offer_vector(KIND_TO_POLAR, 16'h0000, 16'h8000, 15'h0000, 16'h0000);
    offer_vector(KIND_TO_POLAR, 16'h0000, 16'h7FFF, 15'h0000, 16'h0000);
    offer_vector(KIND_TO_POLAR, 16'h7FFF, 16'h8000, 15'h0000, 16'h7FFF);
    offer_vector(KIND_TO_POLAR, 16'h0001, 16'hFFFF, 15'h0000, 16'h0000);
    offer_vector(KIND_TO_POLAR, 16'hFFFD, 16'h0005, 15'h2AAA, 16'h5555);
    // polar to cartesian: zero radius, full radius at axes, half-plane edges, saturation
    offer_vector(KIND_TO_CART, 16'hFFFF, 16'hFFFF, 15'h0000, 16'h0000);
    offer_vector(KIND_TO_CART, 16'h8000, 16'h7FFF, 15'h7FFF, 16'h0000);
    offer_vector(KIND_TO_CART, 16'h0000, 16'h0000, 15'h7FFF, 16'h8000);
    offer_vector(KIND_TO_CART, 16'h0000, 16'h0000, 15'h7FFF, 16'h7FFF);
    offer_vector(KIND_TO_CART, 16'h0000, 16'h0000, 15'h7FFF, 16'h4000);
    offer_vector(KIND_TO_CART, 16'h0000, 16'h0000, 15'h7FFF, 16'hC000);
    offer_vector(KIND_TO_CART, 16'h0000, 16'h0000, 15'd20000, 16'h4001);
    offer_vector(KIND_TO_CART, 16'h0000, 16'h0000, 15'd20000, 16'hBFFF);
    offer_vector(KIND_TO_CART, 16'h0000, 16'h0000, 15'h7FFF, 16'h2000);
    offer_vector(KIND_TO_CART, 16'h0000, 16'h0000, 15'h0001, 16'hCFC7);
    offer_vector(KIND_TO_CART, 16'h5555, 16'hAAAA, 15'h7FFF, 16'h6000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 3))
        0:       radius = 15'h7FFF;
        1:       radius = 15'h0000;
        default: radius = 15'($urandom_range(0, 32767));
      endcase
      offer_vector(kind_t'($urandom_range(0, 1)), pick_word(), pick_word(), radius,
                   pick_word());
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pcc_pkg.sv
sv/pcc_cell.sv
sv/pcc_scale.sv
sv/polar_cartesian_convert.sv
sim/polar_cartesian_checker.sv
sim/polar_cartesian_convert_tb.sv
